FILE: hdl/scs_pkg.sv
`timescale 1ns / 1ps

package scs_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;

    // One queued output job: a single byte, or a held-back slash followed by a byte.
    typedef struct packed {
        logic       pair;
        logic [7:0] data;
    } t_cmd;

endpackage

FILE: hdl/scs_front.sv
`timescale 1ns / 1ps

module scs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output scs_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        NORMAL = 3'd0,
        BLANK  = 3'd1,
        SLASH  = 3'd2,
        LINE   = 3'd3,
        BLOCK  = 3'd4,
        BSTAR  = 3'd5,
        DIRECT = 3'd6
    } t_mode;

    t_mode r_mode;
    t_mode n_mode;
    logic  w_emit;
    logic  w_take;
    logic  w_is_blank;

    assign o_ready    = !i_full;
    assign w_take     = i_valid && o_ready;
    assign w_is_blank = (i_byte == scs_pkg::CH_SP) || (i_byte == scs_pkg::CH_TAB);

    always_comb begin
        n_mode      = r_mode;
        w_emit      = 1'b0;
        o_cmd.pair  = 1'b0;
        o_cmd.data  = i_byte;
        unique case (r_mode)
            SLASH: begin
                if (i_byte == scs_pkg::CH_SLASH) begin
                    n_mode = LINE;
                end else if (i_byte == scs_pkg::CH_STAR) begin
                    n_mode = BLOCK;
                end else begin
                    n_mode     = NORMAL;
                    w_emit     = 1'b1;
                    o_cmd.pair = 1'b1;
                end
            end
            LINE, DIRECT: begin
                if (i_byte == scs_pkg::CH_NL) begin
                    n_mode = NORMAL;
                end
            end
            BLOCK: begin
                if (i_byte == scs_pkg::CH_STAR) begin
                    n_mode = BSTAR;
                end
            end
            BSTAR: begin
                if (i_byte == scs_pkg::CH_SLASH) begin
                    n_mode = NORMAL;
                end else if (i_byte != scs_pkg::CH_STAR) begin
                    n_mode = BLOCK;
                end
            end
            default: begin
                // Normal text; a blank run ends with a byte handled as normal text.
                if (r_mode == BLANK && w_is_blank) begin
                    n_mode = BLANK;
                end else if (w_is_blank) begin
                    n_mode     = BLANK;
                    w_emit     = 1'b1;
                    o_cmd.data = scs_pkg::CH_SP;
                end else if (i_byte == scs_pkg::CH_SLASH) begin
                    n_mode = SLASH;
                end else if (i_byte == scs_pkg::CH_HASH) begin
                    n_mode = DIRECT;
                end else begin
                    n_mode = NORMAL;
                    w_emit = 1'b1;
                end
            end
        endcase
    end

    assign o_push = w_take && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= NORMAL;
        end else if (w_take) begin
            r_mode <= n_mode;
        end
    end

    // A two-byte job can only come out of the slash state.
    a_pair_from_slash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.pair) |-> (r_mode == SLASH))
        else $error("pair job outside slash state");

endmodule

FILE: hdl/scs_queue.sv
`timescale 1ns / 1ps

module scs_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scs_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output scs_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    scs_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into a full queue");

endmodule

FILE: hdl/scs_back.sv
`timescale 1ns / 1ps

module scs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  scs_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_data,
    output logic          o_last
);

    scs_pkg::t_cmd r_cmd;
    logic          r_busy;
    logic          r_phase;
    logic          w_final;

    // The second word of a pair job is the one that closes the job.
    assign w_final   = !r_cmd.pair || r_phase;
    assign o_cmd_pop = i_cmd_valid && (!r_busy || (i_ready && w_final));
    assign o_valid   = r_busy;
    assign o_last    = w_final;
    assign o_data    = (r_cmd.pair && !r_phase) ? scs_pkg::CH_SLASH : r_cmd.data;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (o_cmd_pop) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
        end else if (r_busy && i_ready) begin
            if (w_final) begin
                r_busy  <= 1'b0;
                r_phase <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    a_phase_in_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_busy && r_cmd.pair))
        else $error("second phase outside a pair job");

    a_first_of_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> (o_valid && o_last))
        else $error("pair job lost its closing word");

endmodule

FILE: hdl/source_comment_stripper_core.sv
`timescale 1ns / 1ps

// Strips comments and preprocessor lines from a byte stream of C-like source.
// Slave side: one source byte per word on i_s_tdata, taken when i_s_tvalid
// and o_s_tready are both high. Master side: filtered bytes on o_m_tdata,
// with o_m_tlast high on the final word caused by a given input byte. An
// input byte causes no word (comments, directives, blanks after the first,
// a slash not yet resolved), one word, or two words (a held-back slash then
// the byte after it).
// A classifier takes one byte per cycle while the queue is not full and
// pushes output jobs into a small queue of QUEUE_DEPTH entries; an emitter
// drains it, one word per cycle while i_m_tready is high. An accepted byte's
// first output word is registered in the queue, then in the emitter. A two-word
// job holds the emitter for both words, so the queue absorbs slash-pair bursts.
// When the receiver holds i_m_tready low, the output word is held, the queue
// fills, and o_s_tready drops only once the queue is full.
// A synchronous active-low reset returns the classifier to normal text and
// empties the queue and the output stage.

module source_comment_stripper_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);

    logic          w_full;
    logic          w_push;
    scs_pkg::t_cmd w_push_cmd;
    logic          w_head_valid;
    scs_pkg::t_cmd w_head_cmd;
    logic          w_pop;

    scs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_full  (w_full),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    scs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd),
        .i_pop   (w_pop)
    );

    scs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_last      (o_m_tlast)
    );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int N_ITEMS      = 1100;
    localparam int TAIL_ITEMS   = 150;
    localparam int LONG_HOLD    = 80;
    // Longest legitimate quiet spell is the receiver's long hold with the queue
    // full plus idle bursts on both sides; this is well over.
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 10;

    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_BLANK,
        SCAN_SLASH,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_BLOCK_STAR,
        SCAN_DIRECTIVE
    } t_scan;

    typedef enum int {
        TOK_TEXT,
        TOK_BLANK,
        TOK_LINE,
        TOK_BLOCK,
        TOK_DIRECTIVE,
        TOK_SLASH_PAIR,
        TOK_NOISE,
        TOK_KINDS
    } t_token;

    typedef struct {
        logic [7:0] ch;
        bit         drain;  // sender waits until every expected word has come
        bit         hold;   // receiver starts a long hold-off once this is taken
    } t_src_item;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;    // [7:0] in_byte
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;            // [7:0] out_byte
    logic       o_m_tlast;

    t_src_item  source_feed[$];
    t_word      expected_words[$];
    t_scan      scan_q = SCAN_TEXT;

    int  token_count[TOK_KINDS];
    int  bytes_taken = 0;
    int  words_checked = 0;
    int  long_holds = 0;
    int  err_count = 0;
    int  stall_cycles = 0;
    bit  hold_tog = 1'b0;
    bit  tail_q = 1'b0;

    always #6 i_clk = ~i_clk;

    source_comment_stripper_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Works out the words that one source byte causes and advances the mode.
    task automatic strip_step(input logic [7:0] ch);
        if (scan_q == SCAN_BLANK && (ch == scs_pkg::CH_SP || ch == scs_pkg::CH_TAB))
            return;
        case (scan_q)
            SCAN_SLASH: begin
                if (ch == scs_pkg::CH_SLASH) begin
                    scan_q = SCAN_LINE;
                end else if (ch == scs_pkg::CH_STAR) begin
                    scan_q = SCAN_BLOCK;
                end else begin
                    scan_q = SCAN_TEXT;
                    expected_words.push_back(t_word'{data: scs_pkg::CH_SLASH, last: 1'b0});
                    expected_words.push_back(t_word'{data: ch, last: 1'b1});
                end
            end
            SCAN_LINE, SCAN_DIRECTIVE: begin
                if (ch == scs_pkg::CH_NL)
                    scan_q = SCAN_TEXT;
            end
            SCAN_BLOCK: begin
                if (ch == scs_pkg::CH_STAR)
                    scan_q = SCAN_BLOCK_STAR;
            end
            SCAN_BLOCK_STAR: begin
                if (ch == scs_pkg::CH_SLASH)
                    scan_q = SCAN_TEXT;
                else if (ch != scs_pkg::CH_STAR)
                    scan_q = SCAN_BLOCK;
            end
            default: begin
                // Normal text, which also covers the byte that ends a blank run.
                if (ch == scs_pkg::CH_SP || ch == scs_pkg::CH_TAB) begin
                    scan_q = SCAN_BLANK;
                    expected_words.push_back(t_word'{data: scs_pkg::CH_SP, last: 1'b1});
                end else if (ch == scs_pkg::CH_SLASH) begin
                    scan_q = SCAN_SLASH;
                end else if (ch == scs_pkg::CH_HASH) begin
                    scan_q = SCAN_DIRECTIVE;
                end else begin
                    scan_q = SCAN_TEXT;
                    expected_words.push_back(t_word'{data: ch, last: 1'b1});
                end
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] ch, input bit drain = 1'b0,
                             input bit hold = 1'b0);
        source_feed.push_back(t_src_item'{ch: ch, drain: drain, hold: hold});
    endtask

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] not_newline();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == scs_pkg::CH_NL) ? scs_pkg::CH_SP : b;
    endfunction

    // Brings any mode back to normal text, then lets the sender wait for the
    // block to empty, and after that keeps it offering text while the
    // receiver holds off, so the queue fills and the input stalls.
    task automatic add_pressure();
        push_byte(scs_pkg::CH_NL);
        push_byte(scs_pkg::CH_STAR);
        push_byte(scs_pkg::CH_SLASH);
        push_byte(scs_pkg::CH_NL);
        push_byte(letter(), 1'b1, 1'b0);
        push_byte(letter(), 1'b0, 1'b1);
        for (int k = 0; k < 40; k++)
            push_byte(letter());
    endtask

    // Sender.
    always @(posedge i_clk) begin
        t_src_item item;
        static int tx_idle = 0;
        static int tx_quiet = 0;
        static bit cur_hold = 1'b0;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'h00;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                strip_step(i_s_tdata);
                bytes_taken++;
                if (cur_hold)
                    hold_tog <= ~hold_tog;
            end
            tail_q <= (source_feed.size() < TAIL_ITEMS);
            if (!i_s_tvalid || o_s_tready) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    i_s_tvalid <= 1'b0;
                end else if (source_feed.size() == 0 ||
                             (source_feed[0].drain && expected_words.size() != 0)) begin
                    i_s_tvalid <= 1'b0;
                end else if (!tail_q && tx_quiet == 0 && $urandom_range(0, 4) == 0) begin
                    tx_idle  = $urandom_range(1, 17) - 1;
                    tx_quiet = $urandom_range(0, 40);
                    i_s_tvalid <= 1'b0;
                end else begin
                    item = source_feed.pop_front();
                    cur_hold = item.hold;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= item.ch;
                    if (tx_quiet > 0)
                        tx_quiet--;
                end
            end
        end
    end

    // Receiver and checker.
    always @(posedge i_clk) begin
        t_word exp_w;
        static int rx_idle = 0;
        static int rx_quiet = 0;
        static int rx_hold = 0;
        static bit hold_seen = 1'b0;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: out_byte %h out_last %b", o_m_tdata, o_m_tlast);
                    err_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    words_checked++;
                    if (o_m_tdata !== exp_w.data) begin
                        $error("out_byte: expected %h, got %h", exp_w.data, o_m_tdata);
                        err_count++;
                    end
                    if (o_m_tlast !== exp_w.last) begin
                        $error("out_last: expected %b, got %b", exp_w.last, o_m_tlast);
                        err_count++;
                    end
                end
            end
            if (hold_tog != hold_seen) begin
                hold_seen = hold_tog;
                rx_hold = LONG_HOLD;
                long_holds++;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else if (rx_idle > 0) begin
                rx_idle--;
                i_m_tready <= 1'b0;
            end else if (!tail_q && rx_quiet == 0 && $urandom_range(0, 4) == 0) begin
                rx_idle  = $urandom_range(1, 17) - 1;
                rx_quiet = $urandom_range(0, 40);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (rx_quiet > 0)
                    rx_quiet--;
            end
        end
    end

    // Ends the run when neither side has moved a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int  pick;
        int  n;
        bit  mid_done;
        logic [7:0] b;
        logic [7:0] directed[] = '{
            // blank run ended by text
            8'h00, scs_pkg::CH_SP, scs_pkg::CH_TAB, scs_pkg::CH_SP, "a",
            // line comment
            scs_pkg::CH_SLASH, scs_pkg::CH_SLASH, "c", scs_pkg::CH_NL,
            // directive line
            scs_pkg::CH_HASH, "x", scs_pkg::CH_NL,
            // opening star cannot close
            scs_pkg::CH_SLASH, scs_pkg::CH_STAR, scs_pkg::CH_SLASH,
            // star run closes, next byte kept
            scs_pkg::CH_STAR, scs_pkg::CH_STAR, scs_pkg::CH_SLASH, "z",
            // slash then blank, slash then hash
            scs_pkg::CH_SLASH, scs_pkg::CH_SP, scs_pkg::CH_SLASH, scs_pkg::CH_HASH,
            // slash then newline, top byte
            scs_pkg::CH_SLASH, scs_pkg::CH_NL, 8'hFF
        };

        mid_done = 1'b0;
        foreach (token_count[k])
            token_count[k] = 0;
        foreach (directed[k])
            push_byte(directed[k]);
        add_pressure();

        while (source_feed.size() < N_ITEMS) begin
            if (!mid_done && source_feed.size() >= N_ITEMS / 2) begin
                add_pressure();
                mid_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                token_count[TOK_TEXT]++;
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h21, 8'h7E))
                                                          : letter());
            end else if (pick < 45) begin
                token_count[TOK_BLANK]++;
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    push_byte($urandom_range(0, 1) ? scs_pkg::CH_SP : scs_pkg::CH_TAB);
            end else if (pick < 57) begin
                token_count[TOK_LINE]++;
                push_byte(scs_pkg::CH_SLASH);
                push_byte(scs_pkg::CH_SLASH);
                n = $urandom_range(0, 10);
                for (int k = 0; k < n; k++)
                    push_byte(not_newline());
                push_byte(scs_pkg::CH_NL);
            end else if (pick < 72) begin
                token_count[TOK_BLOCK]++;
                push_byte(scs_pkg::CH_SLASH);
                push_byte(scs_pkg::CH_STAR);
                n = $urandom_range(0, 12);
                for (int k = 0; k < n; k++) begin
                    case ($urandom_range(0, 3))
                        0:       push_byte(scs_pkg::CH_STAR);
                        1:       push_byte(scs_pkg::CH_SLASH);
                        default: push_byte(8'($urandom_range(0, 255)));
                    endcase
                end
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    push_byte(scs_pkg::CH_STAR);
                push_byte(scs_pkg::CH_SLASH);
            end else if (pick < 80) begin
                token_count[TOK_DIRECTIVE]++;
                push_byte(scs_pkg::CH_HASH);
                n = $urandom_range(0, 10);
                for (int k = 0; k < n; k++)
                    push_byte(not_newline());
                push_byte(scs_pkg::CH_NL);
            end else if (pick < 90) begin
                token_count[TOK_SLASH_PAIR]++;
                push_byte(scs_pkg::CH_SLASH);
                case ($urandom_range(0, 5))
                    0: b = scs_pkg::CH_SP;
                    1: b = scs_pkg::CH_TAB;
                    2: b = scs_pkg::CH_HASH;
                    3: b = scs_pkg::CH_NL;
                    default: begin
                        b = 8'($urandom_range(0, 255));
                        if (b == scs_pkg::CH_SLASH || b == scs_pkg::CH_STAR)
                            b = "q";
                    end
                endcase
                push_byte(b);
            end else begin
                // Raw bytes, which may open or break any sequence.
                token_count[TOK_NOISE]++;
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    push_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (source_feed.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Fed %0d source bytes: %0d text runs, %0d blank runs, %0d line comments,",
                 bytes_taken, token_count[TOK_TEXT], token_count[TOK_BLANK],
                 token_count[TOK_LINE]);
        $display("%0d block comments, %0d directives, %0d slash pairs, %0d noise runs;",
                 token_count[TOK_BLOCK], token_count[TOK_DIRECTIVE],
                 token_count[TOK_SLASH_PAIR], token_count[TOK_NOISE]);
        $display("%0d words checked, %0d long holds.", words_checked, long_holds);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
